/* rtl/wtf_pkg.sv */
// Shared types and constants for the word tokenizer and filter.
// No dependencies; used by every module under rtl/.
package wtf_pkg;

   // Fixed widths of the input byte and of the result request fields
   localparam int CHAR_BITS  = 8;
   localparam int COUNT_BITS = 9;
   localparam int START_BITS = 16;
   localparam int REASON_BITS = 3;

   // Drop reason codes
   localparam logic [REASON_BITS-1:0] DROP_KEPT   = 3'd0;
   localparam logic [REASON_BITS-1:0] DROP_SINGLE = 3'd1;
   localparam logic [REASON_BITS-1:0] DROP_NUMBER = 3'd2;
   localparam logic [REASON_BITS-1:0] DROP_ACC6   = 3'd3;
   localparam logic [REASON_BITS-1:0] DROP_ACC8   = 3'd4;

   // Byte class flags; control bytes have all flags low
   typedef struct packed {
      logic digit;
      logic letter;
      logic word_char;
   } char_class_type;

   // One result request from the word tracker
   typedef struct packed {
      logic                   valid;
      logic                   word_found;
      logic [START_BITS-1:0]  word_start;
      logic [COUNT_BITS-1:0]  word_length;
      logic                   keep_word;
      logic [REASON_BITS-1:0] drop_reason;
      logic                   string_done;
   } word_result_type;

endpackage

/* rtl/wtf_char_class.sv */
// Byte classifier: digit, letter and word-character flags for one byte.
// Depends on wtf_pkg.
module wtf_char_class (
   input  logic [wtf_pkg::CHAR_BITS-1:0] char_code,
   output wtf_pkg::char_class_type       char_class
);

   logic is_ctrl;
   logic is_digit;
   logic is_letter;
   logic is_mark;

   // Control bytes behave as spaces, so they match no class
   assign is_ctrl   = char_code inside {[8'h00:8'h1f], [8'h7f:8'hff]};
   assign is_digit  = char_code inside {[8'h30:8'h39]};
   assign is_letter = char_code inside {[8'h41:8'h5a], [8'h61:8'h7a]};
   // - + _ & ' `
   assign is_mark   = char_code inside {8'h2d, 8'h2b, 8'h5f, 8'h26, 8'h27, 8'h60};

   always_comb begin
      char_class.digit     = is_digit & ~is_ctrl;
      char_class.letter    = is_letter & ~is_ctrl;
      char_class.word_char = (is_digit | is_letter | is_mark) & ~is_ctrl;
   end

endmodule

/* rtl/wtf_word_track.sv */
// Word state tracker: offsets, character count, shape flags and drop decision.
// Depends on wtf_pkg; fed by wtf_char_class.
module wtf_word_track #(
   parameter int MAX_WORD    = 512,
   parameter int OFFSET_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  wtf_pkg::char_class_type  char_class,
   input  logic                     last_byte,
   output wtf_pkg::word_result_type result
);

   localparam logic [wtf_pkg::COUNT_BITS-1:0] SplitLen =
      wtf_pkg::COUNT_BITS'(MAX_WORD - 1);

   logic                              in_word_ff, in_word_in;
   logic [OFFSET_BITS-1:0]            byte_offset_ff, byte_offset_in;
   logic [OFFSET_BITS-1:0]            start_offset_ff, start_offset_in;
   logic [wtf_pkg::COUNT_BITS-1:0]    char_count_ff, char_count_in;
   logic                              number_ff, number_in;
   logic                              acc6_ff, acc6_in;
   logic                              acc8_ff, acc8_in;

   logic                              closed;
   logic [OFFSET_BITS-1:0]            w_start;
   logic [wtf_pkg::COUNT_BITS-1:0]    w_count;
   logic                              w_number, w_acc6, w_acc8;
   logic [wtf_pkg::REASON_BITS-1:0]   reason;
   logic [31:0]                       start_wide;

   // Word state update for one byte
   always_comb begin
      closed   = 1'b0;
      w_start  = start_offset_ff;
      w_count  = char_count_ff;
      w_number = number_ff;
      w_acc6   = acc6_ff;
      w_acc8   = acc8_ff;
      if (!in_word_ff) begin
         if (char_class.digit | char_class.letter) begin
            w_start  = byte_offset_ff;
            w_count  = wtf_pkg::COUNT_BITS'(1);
            w_number = char_class.digit;
            w_acc6   = char_class.letter;
            w_acc8   = char_class.letter;
            closed   = last_byte;
         end
      end else if (char_class.word_char) begin
         w_number = number_ff & ~char_class.letter;
         w_acc6   = acc6_ff & char_class.digit;
         // second character of an eight-char accession is a letter
         if (char_count_ff == wtf_pkg::COUNT_BITS'(1)) begin
            w_acc8 = acc8_ff & char_class.letter;
         end else begin
            w_acc8 = acc8_ff & char_class.digit;
         end
         w_count = char_count_ff + wtf_pkg::COUNT_BITS'(1);
         closed  = (w_count >= SplitLen) | last_byte;
      end else begin
         closed = 1'b1;
      end
   end

   // Drop decision, in priority order
   always_comb begin
      if (w_count == wtf_pkg::COUNT_BITS'(1)) begin
         reason = wtf_pkg::DROP_SINGLE;
      end else if (w_number) begin
         reason = wtf_pkg::DROP_NUMBER;
      end else if (w_count == wtf_pkg::COUNT_BITS'(6) && w_acc6) begin
         reason = wtf_pkg::DROP_ACC6;
      end else if (w_count == wtf_pkg::COUNT_BITS'(8) && w_acc8) begin
         reason = wtf_pkg::DROP_ACC8;
      end else begin
         reason = wtf_pkg::DROP_KEPT;
      end
   end

   // Next state
   always_comb begin
      in_word_in      = in_word_ff | char_class.digit | char_class.letter;
      start_offset_in = w_start;
      char_count_in   = w_count;
      number_in       = w_number;
      acc6_in         = w_acc6;
      acc8_in         = w_acc8;
      if (closed) begin
         in_word_in    = 1'b0;
         char_count_in = '0;
         number_in     = 1'b0;
         acc6_in       = 1'b0;
         acc8_in       = 1'b0;
      end
      if (last_byte) begin
         byte_offset_in = '0;
         in_word_in     = 1'b0;
         char_count_in  = '0;
      end else begin
         byte_offset_in = byte_offset_ff + OFFSET_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_word_ff      <= 1'b0;
         byte_offset_ff  <= '0;
         start_offset_ff <= '0;
         char_count_ff   <= '0;
         number_ff       <= 1'b0;
         acc6_ff         <= 1'b0;
         acc8_ff         <= 1'b0;
      end else if (step) begin
         in_word_ff      <= in_word_in;
         byte_offset_ff  <= byte_offset_in;
         start_offset_ff <= start_offset_in;
         char_count_ff   <= char_count_in;
         number_ff       <= number_in;
         acc6_ff         <= acc6_in;
         acc8_ff         <= acc8_in;
      end
   end

   // Result request; fields are zero when no word closed
   assign start_wide = 32'(w_start);

   always_comb begin
      result.valid       = closed | last_byte;
      result.word_found  = closed;
      result.word_start  = closed ? start_wide[wtf_pkg::START_BITS-1:0] : '0;
      result.word_length = closed ? w_count : '0;
      result.keep_word   = closed & (reason == wtf_pkg::DROP_KEPT);
      result.drop_reason = closed ? reason : wtf_pkg::DROP_KEPT;
      result.string_done = last_byte;
   end

endmodule

/* rtl/word_tokenizer_filter_core.sv */
// Word tokenizer and filter, top level: input register, word tracker, result register.
// Depends on wtf_pkg, wtf_char_class and wtf_word_track.
//
// Takes one text byte per request and returns one result request each time a
// word closes (and one for the last byte of every string, which carries
// string_done). A byte is taken every cycle unless the input stage stalls:
// requests land in an input register, the word tracker decides from the
// held byte and updates its state as it moves on, and a result goes into
// the result register. The input stage keeps moving while a result waits,
// as long as the held byte closes no word and is no last byte; a byte that
// does produce a result waits only for the result register to be taken.
// Words longer than MAX_WORD-2 characters are split at MAX_WORD-1; offsets
// count modulo 2^OFFSET_BITS and restart at zero after each string's last byte.
module word_tokenizer_filter_core #(
   parameter int MAX_WORD    = 512,
   parameter int OFFSET_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [wtf_pkg::CHAR_BITS-1:0]     req_char_code,
   input  logic                              req_last_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_word_found,
   output logic [wtf_pkg::START_BITS-1:0]    rsp_word_start,
   output logic [wtf_pkg::COUNT_BITS-1:0]    rsp_word_length,
   output logic                              rsp_keep_word,
   output logic [wtf_pkg::REASON_BITS-1:0]   rsp_drop_reason,
   output logic                              rsp_string_done
);

   logic                              in_valid_ff, in_valid_in;
   logic [wtf_pkg::CHAR_BITS-1:0]     in_char_ff;
   logic                              in_last_ff;
   logic                              out_valid_ff, out_valid_in;
   wtf_pkg::word_result_type          out_data_ff;
   wtf_pkg::char_class_type           char_class;
   wtf_pkg::word_result_type          result;
   logic                              advance;
   logic                              load_out;

   wtf_char_class u_char_class (
      .char_code  (in_char_ff),
      .char_class (char_class)
   );

   wtf_word_track #(
      .MAX_WORD    (MAX_WORD),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_word_track (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .char_class (char_class),
      .last_byte  (in_last_ff),
      .result     (result)
   );

   // Held byte moves on unless its result meets a full result register not being taken
   assign advance  = in_valid_ff & (~result.valid | ~out_valid_ff | rsp_ready);
   assign load_out = advance & result.valid;
   assign req_ready = ~in_valid_ff | advance;

   always_comb begin
      in_valid_in  = req_valid | (in_valid_ff & ~advance);
      out_valid_in = load_out | (out_valid_ff & ~rsp_ready);
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid & req_ready) begin
         in_char_ff <= req_char_code;
         in_last_ff <= req_last_byte;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_data_ff <= result;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_word_found  = out_data_ff.word_found;
   assign rsp_word_start  = out_data_ff.word_start;
   assign rsp_word_length = out_data_ff.word_length;
   assign rsp_keep_word   = out_data_ff.keep_word;
   assign rsp_drop_reason = out_data_ff.drop_reason;
   assign rsp_string_done = out_data_ff.string_done;

endmodule
